[hdl/cdad_pkg.sv]
// Shared types, codes and calendar helpers for the date offset block.
`default_nettype none
package cdad_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'd1;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd2020;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd3000;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DATE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_YEAR_OOR  = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Divisibility by 25: multiply by the inverse of 25 modulo 2^14 and compare
  localparam logic [YEAR_W-1:0] INV25      = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  typedef struct packed {
    logic [YEAR_W-1:0]          start_year;
    logic [MONTH_W-1:0]         start_month;
    logic [DAY_W-1:0]           start_day;
    logic signed [OFFSET_W-1:0] offset_days;
  } cdad_in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   result_year;
    logic [MONTH_W-1:0]  result_month;
    logic [DAY_W-1:0]    result_day;
    logic [STATUS_W-1:0] status;
  } cdad_out_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = year * INV25;
    div25 = (prod <= DIV25_LIMIT);
    // divisible by 4, and either not by 100 or also by 400
    return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[hdl/calendar_date_add_days.sv]
// Gregorian date plus signed day offset, walked month by month.
//
// Input channel in_valid/in_stall/in_data carries a start date and a signed
// day offset; an item is taken on a rising edge with in_valid high and
// in_stall low. The block holds in_stall high while it works on an item.
// Result channel out_valid/out_stall/out_data carries one result per item.
// The result waits in an output register, so the next item can be taken while
// the receiver stalls; a finished walk waits for that register to free up.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) writes min_year and
// max_year; cfg_ready is always high.
//
// A rejected start date goes from ST_LEAP_IN through ST_CHECK to ST_DONE. Otherwise
// ST_CHECK adds the offset and ST_WALK steps the day count with one adder by one
// month length per cycle, pausing in ST_LEAP at each year boundary to refresh
// the leap flag. The block takes no new item until the result of the current
// one is loaded into the output register.
//
// Synchronous active-low reset clears the sequencer and the output valid and
// restores min_year 2020, max_year 3000.
`default_nettype none
module calendar_date_add_days (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire cdad_pkg::cdad_in_t             in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output cdad_pkg::cdad_out_t                 out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [cdad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [cdad_pkg::YEAR_W-1:0]          cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_LEAP_IN = 6'b000010,
    ST_CHECK   = 6'b000100,
    ST_LEAP    = 6'b001000,
    ST_WALK    = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  localparam int YW = 16;  // year register, signed, room to step past either end
  localparam int DW = 18;  // day count, signed, start day plus offset

  state_t                          state_r, state_nxt;
  logic [cdad_pkg::YEAR_W-1:0]     min_year_r, max_year_r;
  logic signed [YW-1:0]            year_r, year_nxt;
  logic [cdad_pkg::MONTH_W-1:0]    month_r, month_nxt;
  logic signed [DW-1:0]            day_r, day_nxt;
  logic signed [cdad_pkg::OFFSET_W-1:0] offset_r;
  logic                            leap_r, leap_nxt;
  logic                            bad_r, bad_nxt;
  logic                            out_valid_r, out_valid_nxt;
  cdad_pkg::cdad_out_t             out_r, out_nxt;

  logic                            in_accept;
  logic                            year_ok;
  logic [cdad_pkg::DAY_W-1:0]      len_cur, len_prev;
  logic                            go_fwd, go_back;
  logic signed [DW-1:0]            step;
  logic                            out_free;

  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign year_ok = (year_r >= $signed({2'b00, min_year_r})) &&
                   (year_r <= $signed({2'b00, max_year_r}));

  assign len_cur  = cdad_pkg::month_len(month_r, leap_r);
  assign len_prev = (month_r == cdad_pkg::MONTH_JAN) ? 5'd31 :
                    cdad_pkg::month_len(month_r - 4'd1, leap_r);
  assign go_fwd   = (day_r > $signed({{(DW-cdad_pkg::DAY_W){1'b0}}, len_cur}));
  assign go_back  = (day_r < $signed(18'sd1));
  // shared adder operand: minus this month's length, or plus the previous one
  assign step     = go_fwd ? -$signed({{(DW-cdad_pkg::DAY_W){1'b0}}, len_cur})
                           :  $signed({{(DW-cdad_pkg::DAY_W){1'b0}}, len_prev});

  always_comb begin
    state_nxt     = state_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    leap_nxt      = leap_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          year_nxt  = $signed({2'b00, in_data.start_year});
          month_nxt = in_data.start_month;
          day_nxt   = $signed({{(DW-cdad_pkg::DAY_W){1'b0}}, in_data.start_day});
          bad_nxt   = 1'b0;
          state_nxt = ST_LEAP_IN;
        end
      end
      ST_LEAP_IN: begin
        leap_nxt  = cdad_pkg::is_leap(year_r[cdad_pkg::YEAR_W-1:0]);
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!year_ok || month_r < cdad_pkg::MONTH_JAN || month_r > cdad_pkg::MONTH_DEC ||
            day_r < $signed(18'sd1) || go_fwd) begin
          bad_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          day_nxt   = day_r + DW'(offset_r);
          state_nxt = ST_WALK;
        end
      end
      ST_LEAP: begin
        leap_nxt  = cdad_pkg::is_leap(year_r[cdad_pkg::YEAR_W-1:0]);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (go_fwd || go_back) begin
          day_nxt = day_r + step;
          if (go_fwd) begin
            if (month_r == cdad_pkg::MONTH_DEC) begin
              month_nxt = cdad_pkg::MONTH_JAN;
              year_nxt  = year_r + 16'sd1;
              state_nxt = ST_LEAP;
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end else begin
            if (month_r == cdad_pkg::MONTH_JAN) begin
              month_nxt = cdad_pkg::MONTH_DEC;
              year_nxt  = year_r - 16'sd1;
              state_nxt = ST_LEAP;
            end else begin
              month_nxt = month_r - 4'd1;
            end
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            out_nxt = '{result_year: '0, result_month: '0, result_day: '0,
                        status: cdad_pkg::STATUS_BAD_DATE};
          end else if (!year_ok) begin
            out_nxt = '{result_year: '0, result_month: '0, result_day: '0,
                        status: cdad_pkg::STATUS_YEAR_OOR};
          end else begin
            out_nxt = '{result_year: year_r[cdad_pkg::YEAR_W-1:0],
                        result_month: month_r,
                        result_day: day_r[cdad_pkg::DAY_W-1:0],
                        status: cdad_pkg::STATUS_OK};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      min_year_r  <= cdad_pkg::MIN_YEAR_RST;
      max_year_r  <= cdad_pkg::MAX_YEAR_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cdad_pkg::CFG_MIN_YEAR: min_year_r <= cfg_data;
          cdad_pkg::CFG_MAX_YEAR: max_year_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    leap_r  <= leap_nxt;
    bad_r   <= bad_nxt;
    out_r   <= out_nxt;
    if (in_accept) begin
      offset_r <= in_data.offset_days;
    end
  end

endmodule
`default_nettype wire

[hdl/cdad_checker.sv]
// Port-level checks for the date offset block, bound to its top level.
`default_nettype none
module cdad_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire cdad_pkg::cdad_out_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != cdad_pkg::STATUS_OK) |->
      out_data.result_year == '0 && out_data.result_month == '0 &&
      out_data.result_day == '0)
    else $error("error result carries a date");

  a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == cdad_pkg::STATUS_OK) |->
      out_data.result_month >= cdad_pkg::MONTH_JAN &&
      out_data.result_month <= cdad_pkg::MONTH_DEC && out_data.result_day != '0)
    else $error("good result with impossible date");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
